// ===== rtl/ldls_pkg.sv =====
// Shared constants, operation codes and digit segment table for the LCD latch shifter.
package ldls_pkg;

  localparam int DIGIT_W = 4;
  localparam int SHOWN_W = 28;
  localparam int SHOWN_LATCHES = SHOWN_W / DIGIT_W;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [3:0] op_t;

  // Operation codes
  localparam op_t OP_DTW   = 4'd0;
  localparam op_t OP_PDTW  = 4'd1;
  localparam op_t OP_WR    = 4'd2;
  localparam op_t OP_WS    = 4'd3;
  localparam op_t OP_TW    = 4'd4;
  localparam op_t OP_PTW   = 4'd5;
  localparam op_t OP_ATBP  = 4'd6;
  localparam op_t OP_COMCN = 4'd7;
  localparam op_t OP_SMF   = 4'd8;
  localparam op_t OP_RMF   = 4'd9;
  localparam op_t OP_SNAP  = 4'd10;
  localparam op_t OP_RET   = 4'd11;

  // WR clears the top accumulator bit, WS sets it
  localparam digit_t WR_MASK = 4'h7;
  localparam digit_t WS_SET  = 4'h8;

  // Return mirrors the display only below this deflicker level
  localparam logic [1:0] DEFLICKER_LIMIT = 2'd2;

  // Segment digits: lower half for CN clear, upper half for CN set
  localparam digit_t DIGIT_TABLE [0:31] = '{
    4'he, 4'h0, 4'hc, 4'h8, 4'h2, 4'ha, 4'he, 4'h2,
    4'he, 4'ha, 4'h0, 4'h0, 4'h2, 4'ha, 4'h2, 4'h2,
    4'hb, 4'h9, 4'h7, 4'hf, 4'hd, 4'he, 4'he, 4'hb,
    4'hf, 4'hf, 4'h4, 4'h0, 4'hd, 4'he, 4'h4, 4'h0
  };

  // Digit inserted by DTW and PDTW; m' is ORed in only when CN is clear
  function automatic digit_t make_digit(logic cn, logic mx, digit_t a);
    digit_t d;
    d = DIGIT_TABLE[{cn, a}];
    if (!cn) begin
      d = d | {{(DIGIT_W-1){1'b0}}, mx};
    end
    return d;
  endfunction

endpackage

// ===== rtl/lcd_digit_latch_shifter.sv =====
// LCD digit latch shifter: shift/output latches, flags and stable display mirror.
// A beat accepted into the input register moves on, once the result register is empty
//   or draining, into the latch/flag state together with the result register.
// Throughput: one beat per cycle unless out_stall holds a result; the only loop is the latch update.
// Reset: rst_n synchronous, active low; clears all latches, flags, deflicker level
//   and both valid bits.
module lcd_digit_latch_shifter
  import ldls_pkg::*;
#(
  parameter int NUM_LATCHES = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           in_operation,
  input  logic [3:0]           in_acc,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_acc_out,
  output logic                 out_backplate,
  output logic                 out_cn_flag,
  output logic                 out_mx_flag,
  output logic [SHOWN_W-1:0]   out_shown_w,
  output logic [SHOWN_W-1:0]   out_shown_wx
);

  localparam int SHOWN_N = (NUM_LATCHES < SHOWN_LATCHES) ? NUM_LATCHES : SHOWN_LATCHES;
  localparam int LAST = NUM_LATCHES - 1;
  localparam int PREV = NUM_LATCHES - 2;

  // config register
  logic [1:0] deflicker_r;

  // input stage
  logic   s1_valid_r;
  op_t    s1_op_r;
  digit_t s1_acc_r;
  logic   s1_adv;

  // result stage and block state
  logic   out_valid_r;
  digit_t acc_out_r, acc_out_nxt;
  logic   cn_r, cn_nxt;
  logic   mx_r, mx_nxt;
  logic   bp_r, bp_nxt;
  digit_t wx_r  [NUM_LATCHES];
  digit_t wx_nxt[NUM_LATCHES];
  digit_t w_r   [NUM_LATCHES];
  digit_t w_nxt [NUM_LATCHES];
  digit_t swx_r  [NUM_LATCHES];
  digit_t swx_nxt[NUM_LATCHES];
  digit_t sw_r   [NUM_LATCHES];
  digit_t sw_nxt [NUM_LATCHES];

  logic   in_accept;
  logic   do_mirror;
  digit_t digit;

  // handshake: stage 1 moves on when the result register is empty or draining
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deflicker_r <= '0;
    end else if (cfg_we) begin
      deflicker_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r  <= in_operation;
      s1_acc_r <= in_acc;
    end
  end

  // next state for one operation
  assign digit = make_digit(cn_r, mx_r, s1_acc_r);

  always_comb begin
    acc_out_nxt = s1_acc_r;
    cn_nxt      = cn_r;
    mx_nxt      = mx_r;
    bp_nxt      = bp_r;
    wx_nxt      = wx_r;
    w_nxt       = w_r;
    do_mirror   = 1'b0;
    unique case (s1_op_r)
      OP_DTW, OP_WR, OP_WS: begin
        for (int i = 0; i < LAST; i++) begin
          wx_nxt[i] = wx_r[i+1];
        end
        if (s1_op_r == OP_DTW) begin
          wx_nxt[LAST] = digit;
        end else if (s1_op_r == OP_WR) begin
          wx_nxt[LAST] = s1_acc_r & WR_MASK;
        end else begin
          wx_nxt[LAST] = s1_acc_r | WS_SET;
        end
      end
      OP_PDTW: begin
        wx_nxt[PREV] = wx_r[LAST];
        wx_nxt[LAST] = digit;
      end
      OP_TW: begin
        w_nxt = wx_r;
      end
      OP_PTW: begin
        w_nxt[LAST] = wx_r[LAST];
        w_nxt[PREV] = wx_r[PREV];
      end
      OP_ATBP: begin
        bp_nxt = s1_acc_r[0];
        cn_nxt = s1_acc_r[3];
      end
      OP_COMCN: cn_nxt = !cn_r;
      OP_SMF:   mx_nxt = 1'b1;
      OP_RMF: begin
        mx_nxt      = 1'b0;
        acc_out_nxt = '0;
      end
      OP_SNAP:  do_mirror = 1'b1;
      OP_RET:   do_mirror = (deflicker_r < DEFLICKER_LIMIT);
      default: ;
    endcase
    // mirror sees the latches as they stand before this beat's own change
    swx_nxt = do_mirror ? wx_r : swx_r;
    sw_nxt  = do_mirror ? w_r  : sw_r;
  end

  // result register and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cn_r <= 1'b0;
      mx_r <= 1'b0;
      bp_r <= 1'b0;
      for (int i = 0; i < NUM_LATCHES; i++) begin
        wx_r[i]  <= '0;
        w_r[i]   <= '0;
        swx_r[i] <= '0;
        sw_r[i]  <= '0;
      end
    end else if (s1_adv) begin
      cn_r  <= cn_nxt;
      mx_r  <= mx_nxt;
      bp_r  <= bp_nxt;
      wx_r  <= wx_nxt;
      w_r   <= w_nxt;
      swx_r <= swx_nxt;
      sw_r  <= sw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      acc_out_r <= acc_out_nxt;
    end
  end

  // pack the mirrored latches that fit the shown fields
  always_comb begin
    out_shown_w  = '0;
    out_shown_wx = '0;
    for (int i = 0; i < SHOWN_N; i++) begin
      out_shown_w[DIGIT_W*i +: DIGIT_W]  = sw_r[i];
      out_shown_wx[DIGIT_W*i +: DIGIT_W] = swx_r[i];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_acc_out   = acc_out_r;
  assign out_backplate = bp_r;
  assign out_cn_flag   = cn_r;
  assign out_mx_flag   = mx_r;

  // checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced beat did not reach result register");

  a_rmf_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_op_r == OP_RMF) |=> (acc_out_r == '0 && !mx_r))
    else $error("RMF did not clear accumulator and m' flag");

  a_shown_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> ($stable(out_shown_w) && $stable(out_shown_wx) && $stable(cn_r)))
    else $error("display state changed without a beat");

endmodule
